>>> design/lraf_pkg.sv
package lraf_pkg;

  // coordinate width and cordic depth
  localparam int CW = 24;
  localparam int CS = 16;

  // derived widths
  localparam int SQW     = 2 * CW;           // sum of squares
  localparam int VW      = CW + 19;          // vectoring cordic x/y
  localparam int RVW     = 33;               // rotation cordic x/y (q30)
  localparam int AW      = 25;               // angle, q16 degrees
  localparam int EW      = 29;               // ring estimate, q16 rings
  localparam int HW      = CW + 1;           // horizontal range magnitude
  localparam int NUMW    = 2 * CW + 2;       // divider numerator
  localparam int QW      = CW + 2;           // divider quotient
  localparam int IN_TDW  = ((3 * CW + 7) / 8) * 8;
  localparam int OUT_TDW = ((3 * CW + 15) / 8) * 8;

  localparam int ATAN_LEN = 24;
  localparam int ATAN_Q16 [ATAN_LEN] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115,
    57, 29, 14, 7, 4, 2, 1, 0
  };
  localparam longint INV_GAIN_Q30 = 652032875;

  typedef enum logic [2:0] {
    CFG_RING_OFFSET    = 3'd0,
    CFG_RINGS_PER_DEG  = 3'd1,
    CFG_RING_TOLERANCE = 3'd2,
    CFG_FALLBACK_RING  = 3'd3,
    CFG_FALLBACK_PITCH = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [SQW-1:0] op;
    logic [CW:0]    rem;
    logic [CW-1:0]  root;
  } sqrt_t;

  typedef struct packed {
    logic [VW-1:0]  vx;
    logic [VW-1:0]  vy;
    logic [AW-1:0]  va;
    logic [RVW-1:0] rx;
    logic [RVW-1:0] ry;
    logic [AW-1:0]  ra;
    logic           flip;
  } cordic_t;

  typedef struct packed {
    logic [CW-1:0] rem;
    logic [QW-1:0] lo;
    logic [QW-1:0] q;
  } div_t;

  // one result bit of the digit-by-digit square root
  function automatic sqrt_t sqrt_step(sqrt_t s);
    logic [CW+2:0] rem2;
    logic [CW+2:0] trial;
    sqrt_t r;
    rem2  = {s.rem, s.op[SQW-1 -: 2]};
    trial = {1'b0, s.root, 2'b01};
    r.op  = s.op << 2;
    if (rem2 >= trial) begin
      r.rem  = (CW+1)'(rem2 - trial);
      r.root = {s.root[CW-2:0], 1'b1};
    end else begin
      r.rem  = (CW+1)'(rem2);
      r.root = {s.root[CW-2:0], 1'b0};
    end
    return r;
  endfunction

  // one micro-rotation of both cordics (vectoring and rotation)
  function automatic cordic_t cordic_step(cordic_t s, int i);
    logic signed [VW-1:0]  vxs;
    logic signed [VW-1:0]  vys;
    logic signed [RVW-1:0] rxs;
    logic signed [RVW-1:0] rys;
    logic [AW-1:0]         at;
    cordic_t r;
    vxs = $signed(s.vx) >>> i;
    vys = $signed(s.vy) >>> i;
    rxs = $signed(s.rx) >>> i;
    rys = $signed(s.ry) >>> i;
    at  = AW'(ATAN_Q16[i]);
    r   = s;
    if (!s.vy[VW-1]) begin
      r.vx = s.vx + vys;
      r.vy = s.vy - vxs;
      r.va = s.va + at;
    end else begin
      r.vx = s.vx - vys;
      r.vy = s.vy + vxs;
      r.va = s.va - at;
    end
    if (!s.ra[AW-1]) begin
      r.rx = s.rx - rys;
      r.ry = s.ry + rxs;
      r.ra = s.ra - at;
    end else begin
      r.rx = s.rx + rys;
      r.ry = s.ry - rxs;
      r.ra = s.ra + at;
    end
    return r;
  endfunction

  // one quotient bit of restoring division
  function automatic div_t div_step(div_t s, logic [CW-1:0] d);
    logic [CW:0] rem2;
    div_t r;
    rem2 = {s.rem, s.lo[QW-1]};
    r.lo = s.lo << 1;
    if (rem2 >= {1'b0, d}) begin
      r.rem = CW'(rem2 - {1'b0, d});
      r.q   = {s.q[QW-2:0], 1'b1};
    end else begin
      r.rem = CW'(rem2);
      r.q   = {s.q[QW-2:0], 1'b0};
    end
    return r;
  endfunction

  // saturate to the coordinate range
  function automatic logic [CW-1:0] sat_coord(logic signed [CW+2:0] v);
    logic signed [CW+2:0] hi;
    logic signed [CW+2:0] lo;
    hi = (CW+3)'((longint'(1) <<< (CW-1)) - 1);
    lo = -hi - 1;
    if (v > hi) begin
      return CW'(hi);
    end else if (v < lo) begin
      return CW'(lo);
    end
    return CW'(v);
  endfunction

endpackage

>>> design/lidar_ring_assign_and_fix_core.sv
// the pipeline depth from an accepted transaction to its result on the master side is set
//   by the bit-per-stage square root and divider and the cordic
// throughput: one transaction per cycle, every stage advances together when the output
//   register is empty or being taken
// reset: asynchronous active low, clears all valid bits and loads the register defaults
module lidar_ring_assign_and_fix_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  // slave side, tdata: x_in, y_in, z_in
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [lraf_pkg::IN_TDW-1:0]  s_axis_tdata,
  // master side, tdata: x_out, y_out, z_out, ring_number
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [lraf_pkg::OUT_TDW-1:0] m_axis_tdata,
  // tuser: was_corrected
  output logic                         m_axis_tuser,
  // register write channel
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [2:0]                   cfg_index_i,
  input  logic [15:0]                  cfg_data_i
);

  localparam int CW = lraf_pkg::CW;
  localparam int CS = lraf_pkg::CS;
  localparam int QW = lraf_pkg::QW;
  localparam int HW = lraf_pkg::HW;
  localparam int RVW = lraf_pkg::RVW;
  localparam int AW = lraf_pkg::AW;
  localparam int EW = lraf_pkg::EW;
  localparam int VW = lraf_pkg::VW;
  localparam int SQW = lraf_pkg::SQW;
  localparam int NUMW = lraf_pkg::NUMW;
  localparam int MPW = CW + RVW - 1;

  // stage map
  localparam int S_SQ   = 1;               // squares
  localparam int S_SUM  = 2;               // sums of squares
  localparam int S_RT0  = S_SUM + 1;       // square roots, one bit a stage
  localparam int S_CV0  = S_RT0 + CW;      // both cordics
  localparam int S_EL   = S_CV0 + CS;      // elevation rounding
  localparam int S_EST  = S_EL + 1;        // ring estimate product
  localparam int S_RING = S_EST + 1;       // rounding, saturation, tolerance test
  localparam int S_M1   = S_RING + 1;      // rho times cos and sin
  localparam int S_M2   = S_M1 + 1;        // q30 rounding
  localparam int S_M3   = S_M2 + 1;        // h times |x| and |y|
  localparam int S_DV0  = S_M3 + 1;        // dividers, one bit a stage
  localparam int S_OUT  = S_DV0 + QW;      // output register
  localparam int NST    = S_OUT + 1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  logic signed [15:0] ring_off_q;
  logic [10:0]        rpd_q;
  logic [7:0]         tol_q;
  logic [6:0]         fb_ring_q;
  logic signed [15:0] fb_pitch_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_off_q <= 16'sd7852;
      rpd_q      <= 11'd192;
      tol_q      <= 8'd26;
      fb_ring_q  <= 7'd2;
      fb_pitch_q <= -16'sd7168;
    end else if (cfg_valid_i) begin
      unique case (lraf_pkg::cfg_idx_e'(cfg_index_i))
        lraf_pkg::CFG_RING_OFFSET:    ring_off_q <= cfg_data_i;
        lraf_pkg::CFG_RINGS_PER_DEG:  rpd_q      <= cfg_data_i[10:0];
        lraf_pkg::CFG_RING_TOLERANCE: tol_q      <= cfg_data_i[7:0];
        lraf_pkg::CFG_FALLBACK_RING:  fb_ring_q  <= cfg_data_i[6:0];
        lraf_pkg::CFG_FALLBACK_PITCH: fb_pitch_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // valid chain, global stall
  // ---------------------------------------------------------------------------
  logic [NST-1:0] vld_q;
  logic           adv;

  // the whole pipe moves while the output register is empty or its transaction completes
  assign adv           = !vld_q[S_OUT] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld_q[S_OUT];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NST-2:0], s_axis_tvalid};
    end
  end

  // ---------------------------------------------------------------------------
  // coordinates travel with the item
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] cx_q [0:S_OUT-1];
  logic signed [CW-1:0] cy_q [0:S_OUT-1];
  logic signed [CW-1:0] cz_q [0:S_OUT-1];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cx_q[0] <= s_axis_tdata[CW-1:0];
      cy_q[0] <= s_axis_tdata[2*CW-1:CW];
      cz_q[0] <= s_axis_tdata[3*CW-1:2*CW];
      for (int k = 1; k < S_OUT; k++) begin
        cx_q[k] <= cx_q[k-1];
        cy_q[k] <= cy_q[k-1];
        cz_q[k] <= cz_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // squares and sums
  // ---------------------------------------------------------------------------
  logic [CW-1:0]  ax0, ay0, az0;
  logic [SQW-1:0] sqx_q, sqy_q, sqz_q;
  logic [SQW-1:0] sxy_q, sall_q;

  always_comb begin
    ax0 = cx_q[S_SQ-1][CW-1] ? CW'(-cx_q[S_SQ-1]) : CW'(cx_q[S_SQ-1]);
    ay0 = cy_q[S_SQ-1][CW-1] ? CW'(-cy_q[S_SQ-1]) : CW'(cy_q[S_SQ-1]);
    az0 = cz_q[S_SQ-1][CW-1] ? CW'(-cz_q[S_SQ-1]) : CW'(cz_q[S_SQ-1]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sqx_q  <= ax0 * ax0;
      sqy_q  <= ay0 * ay0;
      sqz_q  <= az0 * az0;
      sxy_q  <= sqx_q + sqy_q;
      sall_q <= sqx_q + sqy_q + sqz_q;
    end
  end

  // ---------------------------------------------------------------------------
  // square roots: horizontal range and full range
  // ---------------------------------------------------------------------------
  lraf_pkg::sqrt_t sx_q [0:CW-1];
  lraf_pkg::sqrt_t sa_q [0:CW-1];
  lraf_pkg::sqrt_t sx_init, sa_init;

  always_comb begin
    sx_init      = '0;
    sx_init.op   = sxy_q;
    sa_init      = '0;
    sa_init.op   = sall_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sx_q[0] <= lraf_pkg::sqrt_step(sx_init);
      sa_q[0] <= lraf_pkg::sqrt_step(sa_init);
      for (int j = 1; j < CW; j++) begin
        sx_q[j] <= lraf_pkg::sqrt_step(sx_q[j-1]);
        sa_q[j] <= lraf_pkg::sqrt_step(sa_q[j-1]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // cordics: elevation (vectoring) and fallback cos/sin (rotation) side by side
  // ---------------------------------------------------------------------------
  lraf_pkg::cordic_t cv_q [0:CS-1];
  lraf_pkg::cordic_t cv_init;
  logic signed [16:0] pf17;
  logic               pflip;

  always_comb begin
    // pitch beyond a right angle is folded by half a turn, cos and sin negated later
    pf17  = 17'(fb_pitch_q);
    pflip = 1'b0;
    if (pf17 > 17'sd23040) begin
      pf17  = pf17 - 17'sd46080;
      pflip = 1'b1;
    end else if (pf17 < -17'sd23040) begin
      pf17  = pf17 + 17'sd46080;
      pflip = 1'b1;
    end
    cv_init.vx   = VW'({sx_q[CW-1].root, 16'b0});
    cv_init.vy   = VW'($signed({cz_q[S_CV0-1], 16'b0}));
    cv_init.va   = '0;
    cv_init.rx   = RVW'(lraf_pkg::INV_GAIN_Q30);
    cv_init.ry   = '0;
    cv_init.ra   = AW'($signed({pf17[15:0], 8'b0}));
    cv_init.flip = pflip;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      cv_q[0] <= lraf_pkg::cordic_step(cv_init, 0);
      for (int j = 1; j < CS; j++) begin
        cv_q[j] <= lraf_pkg::cordic_step(cv_q[j-1], j);
      end
    end
  end

  // ranges travel from the end of the square roots
  logic [CW-1:0] rxy_q [S_CV0:S_OUT-1];
  logic [CW-1:0] rho_q [S_CV0:S_RING];

  always_ff @(posedge clk_i) begin
    if (adv) begin
      rxy_q[S_CV0] <= sx_q[CW-1].root;
      rho_q[S_CV0] <= sa_q[CW-1].root;
      for (int k = S_CV0 + 1; k < S_OUT; k++) rxy_q[k] <= rxy_q[k-1];
      for (int k = S_CV0 + 1; k <= S_RING; k++) rho_q[k] <= rho_q[k-1];
    end
  end

  // ---------------------------------------------------------------------------
  // elevation in q8 degrees, cos and sin with fold applied
  // ---------------------------------------------------------------------------
  logic signed [15:0]    elev_d, elev_q;
  logic [AW-1:0]         amag;
  logic [AW-1:0]         arnd;
  logic signed [RVW-1:0] c_d, s_d;
  logic signed [RVW-1:0] c_q [S_EL:S_RING];
  logic signed [RVW-1:0] s_q [S_EL:S_RING];

  always_comb begin
    amag = cv_q[CS-1].va[AW-1] ? AW'(-cv_q[CS-1].va) : cv_q[CS-1].va;
    arnd = (amag + AW'(128)) >> 8;
    elev_d = cv_q[CS-1].va[AW-1] ? -16'(arnd) : 16'(arnd);
    // origin point has elevation zero
    if (rxy_q[S_EL-1] == '0 && cz_q[S_EL-1] == '0) elev_d = '0;
    c_d = cv_q[CS-1].flip ? -$signed(cv_q[CS-1].rx) : $signed(cv_q[CS-1].rx);
    s_d = cv_q[CS-1].flip ? -$signed(cv_q[CS-1].ry) : $signed(cv_q[CS-1].ry);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      elev_q   <= elev_d;
      c_q[S_EL] <= c_d;
      s_q[S_EL] <= s_d;
      for (int k = S_EL + 1; k <= S_RING; k++) begin
        c_q[k] <= c_q[k-1];
        s_q[k] <= s_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // ring estimate in q16 rings
  // ---------------------------------------------------------------------------
  logic signed [16:0]   esum;
  logic signed [EW-1:0] est_q;

  assign esum = 17'(elev_q) + 17'(ring_off_q);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      est_q <= EW'(esum) * EW'($signed({1'b0, rpd_q}));
    end
  end

  // ---------------------------------------------------------------------------
  // round, saturate and test against the tolerance
  // ---------------------------------------------------------------------------
  logic [EW-1:0]     emag;
  logic [EW-1:0]     rmag;
  logic signed [EW:0] rfull;
  logic [7:0]        ring8;
  logic signed [29:0] rdiff;
  logic [29:0]       dmag;
  logic              corr_d;
  logic [7:0]        ringb_d;
  logic [7:0]        ring_q [S_RING:S_OUT-1];
  logic              corr_q [S_RING:S_OUT-1];

  always_comb begin
    emag  = est_q[EW-1] ? EW'(-est_q) : EW'(est_q);
    rmag  = (emag + EW'(32768)) >> 16;
    rfull = est_q[EW-1] ? -(EW+1)'(rmag) : (EW+1)'(rmag);
    if (rfull > (EW+1)'(127)) begin
      ring8 = 8'h7f;
    end else if (rfull < -(EW+1)'(128)) begin
      ring8 = 8'h80;
    end else begin
      ring8 = rfull[7:0];
    end
    // distance from the saturated ring, so a clipped estimate fails the test
    rdiff   = 30'(est_q) - $signed({{6{ring8[7]}}, ring8, 16'b0});
    dmag    = rdiff[29] ? 30'(-rdiff) : 30'(rdiff);
    corr_d  = dmag > 30'({tol_q, 8'b0});
    ringb_d = corr_d ? {1'b0, fb_ring_q} : ring8;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ring_q[S_RING] <= ringb_d;
      corr_q[S_RING] <= corr_d;
      for (int k = S_RING + 1; k < S_OUT; k++) begin
        ring_q[k] <= ring_q[k-1];
        corr_q[k] <= corr_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // re-projection: h = rho*cos, z = rho*sin, rounded at q30
  // ---------------------------------------------------------------------------
  logic [RVW-2:0]          cmag, smag;
  logic [MPW-1:0]          hp_q, zp_q;
  logic                    sneg_q;
  logic                    cneg_q [S_M1:S_OUT-1];
  logic [HW-1:0]           hmag_q [S_M2:S_OUT-1];
  logic signed [CW+2:0]    zo_q   [S_M2:S_OUT-1];
  logic [MPW-1:0]          hsum, zsum;
  logic [HW-1:0]           hmag_d, zmag_d;

  always_comb begin
    cmag   = c_q[S_RING][RVW-1] ? (RVW-1)'(-c_q[S_RING]) : (RVW-1)'(c_q[S_RING]);
    smag   = s_q[S_RING][RVW-1] ? (RVW-1)'(-s_q[S_RING]) : (RVW-1)'(s_q[S_RING]);
    hsum   = hp_q + MPW'(1 << 29);
    zsum   = zp_q + MPW'(1 << 29);
    hmag_d = HW'(hsum >> 30);
    zmag_d = HW'(zsum >> 30);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hp_q           <= rho_q[S_RING] * cmag;
      zp_q           <= rho_q[S_RING] * smag;
      cneg_q[S_M1]   <= c_q[S_RING][RVW-1];
      sneg_q         <= s_q[S_RING][RVW-1];
      hmag_q[S_M2]   <= hmag_d;
      zo_q[S_M2]     <= sneg_q ? -(CW+3)'(zmag_d) : (CW+3)'(zmag_d);
      for (int k = S_M1 + 1; k < S_OUT; k++) cneg_q[k] <= cneg_q[k-1];
      for (int k = S_M2 + 1; k < S_OUT; k++) begin
        hmag_q[k] <= hmag_q[k-1];
        zo_q[k]   <= zo_q[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // keep azimuth: |h|*|x|/rxy and |h|*|y|/rxy, rounded half up
  // ---------------------------------------------------------------------------
  logic [CW-1:0]   ax3, ay3;
  logic [NUMW-1:0] numx_q, numy_q;

  always_comb begin
    ax3 = cx_q[S_M3-1][CW-1] ? CW'(-cx_q[S_M3-1]) : CW'(cx_q[S_M3-1]);
    ay3 = cy_q[S_M3-1][CW-1] ? CW'(-cy_q[S_M3-1]) : CW'(cy_q[S_M3-1]);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      numx_q <= NUMW'(hmag_q[S_M3-1]) * NUMW'(ax3) + NUMW'(rxy_q[S_M3-1] >> 1);
      numy_q <= NUMW'(hmag_q[S_M3-1]) * NUMW'(ay3) + NUMW'(rxy_q[S_M3-1] >> 1);
    end
  end

  lraf_pkg::div_t dx_q [0:QW-1];
  lraf_pkg::div_t dy_q [0:QW-1];
  lraf_pkg::div_t dx_init, dy_init;

  // quotient stays below 2^QW, so the top bits already sit below the divisor
  always_comb begin
    dx_init.rem = numx_q[NUMW-1:QW];
    dx_init.lo  = numx_q[QW-1:0];
    dx_init.q   = '0;
    dy_init.rem = numy_q[NUMW-1:QW];
    dy_init.lo  = numy_q[QW-1:0];
    dy_init.q   = '0;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dx_q[0] <= lraf_pkg::div_step(dx_init, rxy_q[S_DV0-1]);
      dy_q[0] <= lraf_pkg::div_step(dy_init, rxy_q[S_DV0-1]);
      for (int j = 1; j < QW; j++) begin
        dx_q[j] <= lraf_pkg::div_step(dx_q[j-1], rxy_q[S_DV0+j-1]);
        dy_q[j] <= lraf_pkg::div_step(dy_q[j-1], rxy_q[S_DV0+j-1]);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output selection and saturation
  // ---------------------------------------------------------------------------
  localparam int L = S_OUT - 1;

  logic signed [CW+2:0] hs, mx, my, xo, yo, zo;
  logic [CW-1:0]        ox_q, oy_q, oz_q;
  logic [7:0]           oring_q;
  logic                 ocorr_q;

  always_comb begin
    hs = cneg_q[L] ? -(CW+3)'(hmag_q[L]) : (CW+3)'(hmag_q[L]);
    mx = (cneg_q[L] != cx_q[L][CW-1]) ? -(CW+3)'(dx_q[QW-1].q) : (CW+3)'(dx_q[QW-1].q);
    my = (cneg_q[L] != cy_q[L][CW-1]) ? -(CW+3)'(dy_q[QW-1].q) : (CW+3)'(dy_q[QW-1].q);
    if (!corr_q[L]) begin
      // point passed the test, coordinates unchanged
      xo = (CW+3)'(cx_q[L]);
      yo = (CW+3)'(cy_q[L]);
      zo = (CW+3)'(cz_q[L]);
    end else if (rxy_q[L] == '0) begin
      // no horizontal range, azimuth taken as zero
      xo = hs;
      yo = '0;
      zo = zo_q[L];
    end else begin
      xo = mx;
      yo = my;
      zo = zo_q[L];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ox_q    <= lraf_pkg::sat_coord(xo);
      oy_q    <= lraf_pkg::sat_coord(yo);
      oz_q    <= lraf_pkg::sat_coord(zo);
      oring_q <= ring_q[L];
      ocorr_q <= corr_q[L];
    end
  end

  assign m_axis_tdata = lraf_pkg::OUT_TDW'({oring_q, oz_q, oy_q, ox_q});
  assign m_axis_tuser = ocorr_q;

endmodule
